>>> rtl/core/stick_square_to_circle_scaling_assert.svh
// ----------------------------------------------------------------------------
// Stick scaling assertion macros
// Concurrent assertion helpers, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STICK_SQUARE_TO_CIRCLE_SCALING_ASSERT_SVH
`define STICK_SQUARE_TO_CIRCLE_SCALING_ASSERT_SVH

`ifndef SYNTHESIS
`define SSC_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("stick scaling assertion failed");
`define SSC_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("stick scaling assertion failed");
`else
`define SSC_ASSERT(lbl, expr)
`define SSC_ASSERT_NEXT(lbl, cond, expr)
`endif

`endif

>>> rtl/core/ssc_pkg.sv
// ----------------------------------------------------------------------------
// Stick scaling package
// Request and result types and default constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int SAMPLE_W             = 12;
    localparam int AXIS_W               = 8;
    localparam int SAMPLE_BITS_DEF      = 12;
    localparam int FACTOR_FRAC_BITS_DEF = 16;
    localparam int POST_SHIFT           = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_x_sample;
        logic [SAMPLE_W-1:0] left_y_sample;
        logic [SAMPLE_W-1:0] right_x_sample;
        logic [SAMPLE_W-1:0] right_y_sample;
    } t_ssc_req;

    typedef struct packed {
        logic signed [AXIS_W-1:0] left_x_axis;
        logic signed [AXIS_W-1:0] left_y_axis;
        logic signed [AXIS_W-1:0] right_x_axis;
        logic signed [AXIS_W-1:0] right_y_axis;
    } t_ssc_rsp;

endpackage

>>> rtl/core/ssc_stick.sv
// ----------------------------------------------------------------------------
// Stick scaling lane
// One stick: center, magnitude, bit-per-stage factor search, scale and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_stick
    import ssc_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF,
    localparam int NST             = FACTOR_FRAC_BITS + 4
) (
    input  logic                     i_clk,
    input  logic [NST-1:0]           i_en,
    input  logic [SAMPLE_BITS-1:0]   i_center,
    input  logic [SAMPLE_BITS-1:0]   i_sx,
    input  logic [SAMPLE_BITS-1:0]   i_sy,
    input  logic                     i_neg_x,
    input  logic                     i_neg_y,
    output logic signed [AXIS_W-1:0] o_x,
    output logic signed [AXIS_W-1:0] o_y
);

    localparam int S   = SAMPLE_BITS;
    localparam int F   = FACTOR_FRAC_BITS;
    localparam int SQW = 2 * S + 1;
    localparam int RW  = 2 * S + 2 * F;
    localparam int CW  = 2 * S + 2 * F + 3;
    localparam int FW  = F + 1;
    localparam int PW  = S + F + 1;

    logic [S:0]   w_dx;
    logic [S:0]   w_dy;
    logic [S-1:0] r0_ax;
    logic [S-1:0] r0_ay;
    logic         r0_nx;
    logic         r0_ny;

    assign w_dx = {1'b0, i_sx} - {1'b0, i_center};
    assign w_dy = {1'b0, i_sy} - {1'b0, i_center};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_ax <= w_dx[S] ? S'(-w_dx) : w_dx[S-1:0];
            r0_ay <= w_dy[S] ? S'(-w_dy) : w_dy[S-1:0];
            r0_nx <= w_dx[S] ^ i_neg_x;
            r0_ny <= w_dy[S] ^ i_neg_y;
        end
    end

    logic [S-1:0]   w_m;
    logic [2*S-1:0] w_m2;
    logic [S-1:0]   r1_ax;
    logic [S-1:0]   r1_ay;
    logic           r1_nx;
    logic           r1_ny;
    logic [SQW-1:0] r1_s;
    logic [RW-1:0]  r1_r;

    assign w_m  = (r0_ax > r0_ay) ? r0_ax : r0_ay;
    assign w_m2 = w_m * w_m;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_ax <= r0_ax;
            r1_ay <= r0_ay;
            r1_nx <= r0_nx;
            r1_ny <= r0_ny;
            r1_s  <= SQW'(r0_ax * r0_ax) + SQW'(r0_ay * r0_ay);
            r1_r  <= {w_m2, {(2 * F){1'b0}}};
        end
    end

    logic [S-1:0]   r_ax [0:F];
    logic [S-1:0]   r_ay [0:F];
    logic           r_nx [0:F];
    logic           r_ny [0:F];
    logic [SQW-1:0] r_s  [0:F];
    logic [RW-1:0]  r_r  [0:F];
    logic [CW-1:0]  r_p  [0:F];
    logic [CW-1:0]  r_q  [0:F];
    logic [FW-1:0]  r_f  [0:F];

    genvar k;
    generate
        for (k = 0; k <= F; k++) begin : g_step
            localparam int B = F - k;
            logic [S-1:0]   w_ax;
            logic [S-1:0]   w_ay;
            logic           w_nx;
            logic           w_ny;
            logic [SQW-1:0] w_s;
            logic [RW-1:0]  w_r;
            logic [CW-1:0]  w_p;
            logic [CW-1:0]  w_q;
            logic [FW-1:0]  w_f;
            logic [CW-1:0]  w_cand;
            logic           w_take;

            if (k == 0) begin : g_first
                assign w_ax = r1_ax;
                assign w_ay = r1_ay;
                assign w_nx = r1_nx;
                assign w_ny = r1_ny;
                assign w_s  = r1_s;
                assign w_r  = r1_r;
                assign w_p  = '0;
                assign w_q  = '0;
                assign w_f  = '0;
            end else begin : g_next
                assign w_ax = r_ax[k-1];
                assign w_ay = r_ay[k-1];
                assign w_nx = r_nx[k-1];
                assign w_ny = r_ny[k-1];
                assign w_s  = r_s[k-1];
                assign w_r  = r_r[k-1];
                assign w_p  = r_p[k-1];
                assign w_q  = r_q[k-1];
                assign w_f  = r_f[k-1];
            end

            assign w_cand = w_p + (w_q << (B + 1)) + (CW'(w_s) << (2 * B));
            assign w_take = (w_cand <= CW'(w_r));

            always_ff @(posedge i_clk) begin
                if (i_en[k+2]) begin
                    r_ax[k] <= w_ax;
                    r_ay[k] <= w_ay;
                    r_nx[k] <= w_nx;
                    r_ny[k] <= w_ny;
                    r_s[k]  <= w_s;
                    r_r[k]  <= w_r;
                    r_p[k]  <= w_take ? w_cand : w_p;
                    r_q[k]  <= w_take ? (w_q + (CW'(w_s) << B)) : w_q;
                    r_f[k]  <= w_take ? (w_f | (FW'(1) << B)) : w_f;
                end
            end
        end
    endgenerate

    function automatic logic signed [AXIS_W-1:0] clamp_axis(
        input logic [PW-1:0] prod,
        input logic          neg
    );
        logic [PW-1:0] q;
        begin
            q = prod >> (F + POST_SHIFT);
            if (neg) begin
                clamp_axis = (q >= PW'(128)) ? AXIS_W'(-128) : AXIS_W'(-q);
            end else begin
                clamp_axis = (q >= PW'(127)) ? AXIS_W'(127) : AXIS_W'(q);
            end
        end
    endfunction

    logic [PW-1:0] w_px;
    logic [PW-1:0] w_py;

    assign w_px = PW'(r_ax[F]) * PW'(r_f[F]);
    assign w_py = PW'(r_ay[F]) * PW'(r_f[F]);

    always_ff @(posedge i_clk) begin
        if (i_en[NST-1]) begin
            o_x <= clamp_axis(w_px, r_nx[F]);
            o_y <= clamp_axis(w_py, r_ny[F]);
        end
    end

endmodule

>>> rtl/core/stick_square_to_circle_scaling.sv
// ----------------------------------------------------------------------------
// Square-to-circle stick scaling
// Takes one request of four stick samples per cycle while the output is not
// stalled and returns four axes, each stick vector scaled by
// max(|x|,|y|)/sqrt(x^2+y^2), divided by 16 and clamped to -128..127. The
// pipeline has one stage per bit of the scale factor search. Every stage
// holds under backpressure and bubbles close up, so a request is taken while
// a result still waits, unless every stage is full.
// The center register is written through its own port, always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stick_square_to_circle_scaling_assert.svh"

module stick_square_to_circle_scaling
    import ssc_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_ssc_req            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_ssc_rsp            o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SAMPLE_W-1:0] i_cfg_data
);

    localparam int NST = FACTOR_FRAC_BITS + 4;

    logic [SAMPLE_BITS-1:0] r_center;
    logic [NST-1:0]         r_valid;
    logic [NST:0]           w_ready;

    assign w_ready[NST] = i_out_ready;

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_ready
            assign w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
            r_valid  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_center <= SAMPLE_BITS'(i_cfg_data);
            end
            if (w_ready[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_ready[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
        end
    end

    assign o_in_ready  = w_ready[0];
    assign o_out_valid = r_valid[NST-1];
    assign o_cfg_ready = 1'b1;

    ssc_stick #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_left (
        .i_clk    (i_clk),
        .i_en     (w_ready[NST-1:0]),
        .i_center (r_center),
        .i_sx     (SAMPLE_BITS'(i_in_data.left_x_sample)),
        .i_sy     (SAMPLE_BITS'(i_in_data.left_y_sample)),
        .i_neg_x  (1'b1),
        .i_neg_y  (1'b0),
        .o_x      (o_out_data.left_x_axis),
        .o_y      (o_out_data.left_y_axis)
    );

    ssc_stick #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_right (
        .i_clk    (i_clk),
        .i_en     (w_ready[NST-1:0]),
        .i_center (r_center),
        .i_sx     (SAMPLE_BITS'(i_in_data.right_x_sample)),
        .i_sy     (SAMPLE_BITS'(i_in_data.right_y_sample)),
        .i_neg_x  (1'b0),
        .i_neg_y  (1'b1),
        .o_x      (o_out_data.right_x_axis),
        .o_y      (o_out_data.right_y_axis)
    );

    `SSC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data))
    `SSC_ASSERT(a_full_stall, !((&r_valid) && !i_out_ready && o_in_ready))
    `SSC_ASSERT_NEXT(a_cfg_write, i_cfg_valid,
        r_center == SAMPLE_BITS'($past(i_cfg_data)))
    `SSC_ASSERT_NEXT(a_accept_enters, i_in_valid && o_in_ready, r_valid[0])

endmodule
